// ===== src/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands used by the RTL. Each macro samples on clk and is
// disabled while rst_n is low. The using module must provide clk and rst_n.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/kce_pkg.sv =====
// ----------------------------------------------------------------------------
// kce_pkg
// Shared constants and types of the k-combination enumerator.
// ----------------------------------------------------------------------------
`default_nettype none

package kce_pkg;

  localparam int MAX_K      = 8;
  localparam int MAX_N      = 64;
  localparam int ELEM_W     = 6;
  localparam int N_W        = 7;
  localparam int K_W        = 4;
  localparam int K_IDX_W    = $clog2(MAX_K);
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 7;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_N_ITEMS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_K_SIZE  = 2'd1;

  localparam logic [N_W-1:0] N_RESET = 7'd8;
  localparam logic [K_W-1:0] K_RESET = 4'd2;

  typedef logic [ELEM_W-1:0] elem_t;
  typedef elem_t [MAX_K-1:0] combo_t;

  typedef struct packed {
    logic [N_W-1:0] n_eff;   // set size, saturated
    logic [K_W-1:0] k;       // combination size
    logic           valid;   // 1 <= k <= MAX_K and k <= n
  } size_cfg_t;

  typedef struct packed {
    combo_t combo;      // next stored combination
    logic   finished;   // next finished flag
    combo_t elems;      // result slots, zero beyond k
    logic   last;
    logic   exhausted;
  } step_t;

endpackage

`default_nettype wire

// ===== src/kce_in_if.sv =====
// ----------------------------------------------------------------------------
// kce_in_if
// Input channel: one request per transfer, restart or advance.
// ----------------------------------------------------------------------------
`default_nettype none

interface kce_in_if;
  logic valid;
  logic ready;
  logic restart;

  modport source (output valid, output restart, input ready);
  modport sink   (input valid, input restart, output ready);
endinterface

`default_nettype wire

// ===== src/kce_out_if.sv =====
// ----------------------------------------------------------------------------
// kce_out_if
// Result channel: one combination per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

interface kce_out_if;
  import kce_pkg::*;
  logic  valid;
  logic  ready;
  elem_t elem_0;
  elem_t elem_1;
  elem_t elem_2;
  elem_t elem_3;
  elem_t elem_4;
  elem_t elem_5;
  elem_t elem_6;
  elem_t elem_7;
  logic  last_combo;
  logic  exhausted;

  modport source (output valid, output elem_0, output elem_1, output elem_2,
                  output elem_3, output elem_4, output elem_5, output elem_6,
                  output elem_7, output last_combo, output exhausted,
                  input ready);
  modport sink   (input valid, input elem_0, input elem_1, input elem_2,
                  input elem_3, input elem_4, input elem_5, input elem_6,
                  input elem_7, input last_combo, input exhausted,
                  output ready);
endinterface

`default_nettype wire

// ===== src/kce_cfg_if.sv =====
// ----------------------------------------------------------------------------
// kce_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
`default_nettype none

interface kce_cfg_if;
  import kce_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== src/kce_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// kce_cfg_regs
// Holds n_items and k_size, derives the effective sizes and their validity.
// ----------------------------------------------------------------------------
`default_nettype none

module kce_cfg_regs (
  input  logic               clk,
  input  logic               rst_n,
  kce_cfg_if.sink            cfg_ch,
  output kce_pkg::size_cfg_t size,
  output logic               seq_clr   // a known register was written
);
  import kce_pkg::*;

  logic [N_W-1:0] n_r;
  logic [K_W-1:0] k_r;
  logic           wr;

  assign cfg_ch.ready = 1'b1;
  assign wr           = cfg_ch.valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n_r <= N_RESET;
      k_r <= K_RESET;
    end else if (wr) begin
      case (cfg_ch.index)
        CFG_N_ITEMS: n_r <= cfg_ch.data[N_W-1:0];
        CFG_K_SIZE:  k_r <= cfg_ch.data[K_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    seq_clr = wr && ((cfg_ch.index == CFG_N_ITEMS) || (cfg_ch.index == CFG_K_SIZE));
    size.n_eff = (n_r > N_W'(MAX_N)) ? N_W'(MAX_N) : n_r;
    size.k     = k_r;
    size.valid = (k_r != '0) && (k_r <= K_W'(MAX_K)) && (N_W'(k_r) <= size.n_eff);
  end

endmodule

`default_nettype wire

// ===== src/kce_succ.sv =====
// ----------------------------------------------------------------------------
// kce_succ
// One enumeration step: first combination or lexicographic successor.
// ----------------------------------------------------------------------------
`default_nettype none

module kce_succ (
  input  logic               restart,
  input  logic               started,
  input  logic               finished,
  input  kce_pkg::combo_t    combo,
  input  kce_pkg::size_cfg_t size,
  output kce_pkg::step_t     step
);
  import kce_pkg::*;

  logic               first;
  logic [N_W-1:0]     span;      // n - k, value of slot 0 in the final combination
  logic [MAX_K-1:0]   in_k;
  logic [MAX_K-1:0]   grow;
  logic               found;
  logic [K_IDX_W-1:0] piv_idx;
  elem_t              piv_inc;
  combo_t             adv;
  combo_t             init;
  combo_t             nxt;
  logic               exh;

  always_comb begin
    first = restart || !started;
    span  = size.n_eff - N_W'(size.k);

    for (int i = 0; i < MAX_K; i++) begin
      in_k[i] = K_W'(i) < size.k;
      grow[i] = in_k[i] && ({1'b0, combo[i]} < (span + N_W'(i)));
      init[i] = (size.valid && in_k[i]) ? ELEM_W'(i) : '0;
    end

    // rightmost slot that can still grow
    found   = 1'b0;
    piv_idx = '0;
    for (int i = 0; i < MAX_K; i++) begin
      if (grow[i]) begin
        found   = 1'b1;
        piv_idx = K_IDX_W'(i);
      end
    end

    piv_inc = combo[piv_idx] + ELEM_W'(1);
    for (int i = 0; i < MAX_K; i++) begin
      if (in_k[i] && (K_IDX_W'(i) >= piv_idx)) begin
        adv[i] = piv_inc + ELEM_W'(i) - ELEM_W'(piv_idx);
      end else begin
        adv[i] = combo[i];
      end
    end

    if (first) begin
      nxt           = init;
      step.finished = !size.valid;
      exh           = !size.valid;
    end else if (finished || !size.valid || !found) begin
      nxt           = combo;
      step.finished = 1'b1;
      exh           = 1'b1;
    end else begin
      nxt           = adv;
      step.finished = 1'b0;
      exh           = 1'b0;
    end

    step.combo     = nxt;
    step.exhausted = exh;
    step.last      = !exh && ({1'b0, nxt[0]} == span);
    for (int j = 0; j < MAX_K; j++) begin
      step.elems[j] = (!exh && in_k[j]) ? nxt[j] : '0;
    end
  end

endmodule

`default_nettype wire

// ===== src/k_combination_enumerator.sv =====
// ----------------------------------------------------------------------------
// k_combination_enumerator
// Lexicographic k-subset generator over {0..n-1}, one combination per request.
// ----------------------------------------------------------------------------
// A restart request returns 0,1,..,k-1; any other request returns the next
// k-subset in lexicographic order, with slots at or beyond k reading zero and
// last_combo marking the final subset. Once the sequence is done, or when the
// sizes are unusable (k of zero, above 8, or above n; n saturates at 64), the
// result reads exhausted with all slots zero. A request before any restart
// behaves as a restart, and writing n_items or k_size starts a new sequence
// on the next request. Write configuration only while no request is in
// flight. Throughput is one request per cycle unless out_ch.ready is low; a
// request moves from the input register through the successor logic into the
// result register. The successor step (parallel slot compare, rightmost-pivot
// pick and refill) sits between those two registers and sets the clock period.
// Configuration writes are always taken (cfg_ch.ready is tied high).
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module k_combination_enumerator (
  input  logic     clk,
  input  logic     rst_n,
  kce_in_if.sink   in_ch,
  kce_out_if.source out_ch,
  kce_cfg_if.sink  cfg_ch
);
  import kce_pkg::*;

  size_cfg_t size;
  logic      seq_clr;
  step_t     step;

  // input register
  logic in_v_r, in_v_nxt;
  logic in_restart_r;

  // enumeration state
  logic   started_r, started_nxt;
  logic   finished_r, finished_nxt;
  combo_t combo_r, combo_nxt;

  // result register
  logic   out_v_r, out_v_nxt;
  combo_t out_elems_r;
  logic   out_last_r;
  logic   out_exh_r;

  logic advance;   // input register moves into the result register
  logic first;
  logic exh_clean; // result slots and last flag all zero
  logic fin_adv;   // advance request on a finished sequence

  kce_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg_ch  (cfg_ch),
    .size    (size),
    .seq_clr (seq_clr)
  );

  kce_succ u_succ (
    .restart  (in_restart_r),
    .started  (started_r),
    .finished (finished_r),
    .combo    (combo_r),
    .size     (size),
    .step     (step)
  );

  // the result slot frees up on the same cycle it is taken
  assign advance     = in_v_r && (!out_v_r || out_ch.ready);
  assign in_ch.ready = !in_v_r || advance;
  assign first       = in_restart_r || !started_r;
  assign exh_clean   = (out_elems_r == '0) && !out_last_r;
  assign fin_adv     = advance && !first && finished_r && !seq_clr;

  always_comb begin
    in_v_nxt = in_ch.valid || (in_v_r && !advance);
    out_v_nxt = advance || (out_v_r && !out_ch.ready);

    started_nxt  = started_r;
    finished_nxt = finished_r;
    combo_nxt    = combo_r;
    if (seq_clr) begin
      // new sizes: next request opens a fresh sequence
      started_nxt  = 1'b0;
      finished_nxt = 1'b0;
    end else if (advance) begin
      started_nxt  = 1'b1;
      finished_nxt = step.finished;
      combo_nxt    = step.combo;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r     <= 1'b0;
      out_v_r    <= 1'b0;
      started_r  <= 1'b0;
      finished_r <= 1'b0;
      combo_r    <= '0;
    end else begin
      in_v_r     <= in_v_nxt;
      out_v_r    <= out_v_nxt;
      started_r  <= started_nxt;
      finished_r <= finished_nxt;
      combo_r    <= combo_nxt;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      in_restart_r <= in_ch.restart;
    end
    if (advance) begin
      out_elems_r <= step.elems;
      out_last_r  <= step.last;
      out_exh_r   <= step.exhausted;
    end
  end

  assign out_ch.valid      = out_v_r;
  assign out_ch.elem_0     = out_elems_r[0];
  assign out_ch.elem_1     = out_elems_r[1];
  assign out_ch.elem_2     = out_elems_r[2];
  assign out_ch.elem_3     = out_elems_r[3];
  assign out_ch.elem_4     = out_elems_r[4];
  assign out_ch.elem_5     = out_elems_r[5];
  assign out_ch.elem_6     = out_elems_r[6];
  assign out_ch.elem_7     = out_elems_r[7];
  assign out_ch.last_combo = out_last_r;
  assign out_ch.exhausted  = out_exh_r;

  // exhausted results carry no combination
  `ASSERT_IMPL(a_exh_zero, out_v_r && out_exh_r, exh_clean, "exhausted result carries data")

  // a finished sequence stays exhausted until restarted
  `ASSERT_NEXT(a_fin_sticky, fin_adv, out_exh_r && finished_r, "finished sequence advanced")

  // a blocked request is held in the input register
  `ASSERT_NEXT(a_in_hold, in_v_r && !advance, in_v_r, "pending request dropped")

  // sequence state is only cleared by a register write or by reset
  `ASSERT_IMPL(a_start_clr, $fell(started_r), $past(seq_clr || !rst_n), "stray sequence clear")

endmodule

`default_nettype wire
